// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL that checks its own behavior (the top level includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/tdpt_pkg.sv =====
// Package with the command and status structs shared by controller and datapath.
package tdpt_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new number, reset divisor to 2
    logic init_div;  // clear remainder, point at the top bit of the number
    logic step_div;  // one restoring remainder step
    logic next_div;  // advance to the next divisor and its square
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_le1;     // number is zero or one
    logic sq_gt_n;   // divisor squared exceeds the number
    logic div_last;  // current remainder step is the last one
    logic rem_zero;  // remainder of the finished division is zero
  } stat_t;

endpackage

// ===== sv/tdpt_datapath.sv =====
// Datapath: number, divisor, divisor square and a bit-serial remainder unit.
module tdpt_datapath #(
  parameter int NUM_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [NUM_WIDTH-1:0] number_i,
  input  tdpt_pkg::cmd_t       cmd_i,
  output tdpt_pkg::stat_t      stat_o
);
  import tdpt_pkg::*;

  localparam int CntWidth = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;
  localparam int SqWidth  = NUM_WIDTH + 2;

  logic [NUM_WIDTH-1:0] n_q, n_d;
  logic [NUM_WIDTH-1:0] d_q, d_d;
  logic [SqWidth-1:0]   sq_q, sq_d;
  logic [NUM_WIDTH-1:0] rem_q, rem_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;

  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   diff;

  // Shift the next number bit into the partial remainder, subtract if it fits.
  assign trial = {rem_q, n_q[cnt_q]};
  assign diff  = trial - {1'b0, d_q};

  always_comb begin
    n_d   = n_q;
    d_d   = d_q;
    sq_d  = sq_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      n_d  = number_i;
      d_d  = NUM_WIDTH'(2);
      sq_d = SqWidth'(4);
    end
    if (cmd_i.init_div) begin
      rem_d = '0;
      cnt_d = CntWidth'(NUM_WIDTH - 1);
    end
    if (cmd_i.step_div) begin
      if (diff[NUM_WIDTH]) begin
        rem_d = trial[NUM_WIDTH-1:0];
      end else begin
        rem_d = diff[NUM_WIDTH-1:0];
      end
      cnt_d = cnt_q - CntWidth'(1);
    end
    if (cmd_i.next_div) begin
      // (d+1)^2 = d^2 + 2d + 1
      d_d  = d_q + NUM_WIDTH'(1);
      sq_d = sq_q + {1'b0, d_q, 1'b0} + SqWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    sq_q  <= sq_d;
    rem_q <= rem_d;
  end

  assign stat_o.n_le1    = (n_q <= NUM_WIDTH'(1));
  assign stat_o.sq_gt_n  = (sq_q > {2'b00, n_q});
  assign stat_o.div_last = (cnt_q == '0);
  assign stat_o.rem_zero = (rem_q == '0);

endmodule

// ===== sv/tdpt_controller.sv =====
// Controller: state machine that sequences the divisor search and the result strobe.
module tdpt_controller (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  output logic            valid_o,
  output logic            is_prime_o,
  input  tdpt_pkg::stat_t stat_i,
  output tdpt_pkg::cmd_t  cmd_o
);
  import tdpt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_TEST  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   prime_q, prime_d;

  always_comb begin
    state_d = state_q;
    prime_d = prime_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.n_le1) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else if (stat_i.sq_gt_n) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.init_div = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step_div = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (stat_i.rem_zero) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prime_q <= prime_d;
  end

  assign busy       = (state_q != ST_IDLE);
  assign valid_o    = (state_q == ST_DONE);
  assign is_prime_o = prime_q;

endmodule

// ===== sv/trial_division_prime_test.sv =====
// Top level of the trial-division prime test: controller, datapath and self-checks.
// A prime verdict (and that for zero or one) is given from the check state, a composite one
// straight from the remainder test; the number of divisors tried is at most
// floor(sqrt(number))-1, and each is divided by the bit-serial remainder unit, one bit per
// cycle. One item at a time: the next start is taken the cycle after the strobe.
// Reset (rst_ni low, asynchronous) returns to idle, no result.
module trial_division_prime_test #(
  parameter int NUM_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] number_i,
  output logic                 busy,
  output logic                 valid_o,
  output logic                 is_prime_o
);
  import tdpt_pkg::*;

  `include "assert_macros.svh"

  cmd_t  cmd;
  stat_t stat;

  // Sequence: idle -> check (zero/one, square past number) -> divide NUM_WIDTH steps
  // -> test remainder -> back to check with the next divisor, or done.
  tdpt_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .valid_o    (valid_o),
    .is_prime_o (is_prime_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold the number, walk the divisor upward from 2 and track its square by adding 2d+1.
  tdpt_datapath #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .number_i (number_i),
    .cmd_i    (cmd),
    .stat_o   (stat)
  );

  // An accepted item keeps the block busy until its strobe.
  `ASSERT_NXT(a_start_busy, start && !busy, busy)
  // The strobe is a single cycle and frees the block.
  `ASSERT_NXT(a_strobe_free, valid_o, !busy && !valid_o)
  // Zero and one are never reported prime.
  `ASSERT_IMP(a_small_not_prime, valid_o && stat.n_le1, !is_prime_o)
  // A prime verdict means the divisor search ran past the square root.
  `ASSERT_IMP(a_prime_sq, valid_o && is_prime_o, stat.sq_gt_n)

endmodule
